// File: sv/blr_pkg.sv
`default_nettype none
package blr_pkg;

  localparam int COORD_BITS  = 16;
  localparam int DIM_BITS    = 12;
  localparam int CFG_BITS    = 13;
  localparam int COLOUR_BITS = 8;
  localparam int INDEX_BITS  = 24;

  // coordinate difference and error term widths
  localparam int DELTA_BITS = COORD_BITS + 1;
  localparam int ERR_BITS   = COORD_BITS + 3;

  // clamped frame size, compare width and index product width
  localparam int DIM_W  = (CFG_BITS > DIM_BITS + 1) ? CFG_BITS : DIM_BITS + 1;
  localparam int CMP_W  = (COORD_BITS > DIM_W) ? COORD_BITS : DIM_W;
  localparam int PROD_W = (DIM_BITS + DIM_W > INDEX_BITS) ? DIM_BITS + DIM_W : INDEX_BITS;
  localparam logic [DIM_W-1:0] DIM_LIMIT = DIM_W'(1) << DIM_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // request kinds
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // configuration register indexes
  localparam logic CFG_FRAME_WIDTH  = 1'b0;
  localparam logic CFG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_BITS-1:0] FRAME_WIDTH_RST  = CFG_BITS'(640);
  localparam logic [CFG_BITS-1:0] FRAME_HEIGHT_RST = CFG_BITS'(480);

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [ERR_BITS-1:0]   err_t;

  typedef struct packed {
    logic                   req_type;
    coord_t                 x_start;
    coord_t                 y_start;
    coord_t                 x_end;
    coord_t                 y_end;
    logic [COLOUR_BITS-1:0] red_in;
    logic [COLOUR_BITS-1:0] green_in;
    logic [COLOUR_BITS-1:0] blue_in;
  } req_t;

  typedef struct packed {
    logic                   pixel_valid;
    coord_t                 pixel_x;
    coord_t                 pixel_y;
    logic                   in_frame;
    logic [INDEX_BITS-1:0]  pixel_index;
    logic [COLOUR_BITS-1:0] red_out;
    logic [COLOUR_BITS-1:0] green_out;
    logic [COLOUR_BITS-1:0] blue_out;
    logic                   last_pixel;
  } res_t;

  typedef struct packed {
    logic [COLOUR_BITS-1:0] red;
    logic [COLOUR_BITS-1:0] green;
    logic [COLOUR_BITS-1:0] blue;
  } colour_t;

  // decoded command handed from front to back
  typedef struct packed {
    logic    is_start;
    logic    x_major;
    logic    minor_up;
    coord_t  cur_x;
    coord_t  cur_y;
    coord_t  major_end;
    err_t    err;
    err_t    err_straight;
    err_t    err_diag;
    colour_t colour;
  } cmd_t;

  // stepped pixel, before frame test and index
  typedef struct packed {
    logic    pixel_valid;
    coord_t  x;
    coord_t  y;
    logic    last;
    colour_t colour;
  } pix_t;

endpackage
`default_nettype wire

// File: sv/blr_front.sv
`default_nettype none
module blr_front
  import blr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req_data,
  output logic cmd_valid,
  input  logic cmd_full,
  output cmd_t cmd
);

  logic                           f_vld;
  logic                           f_start;
  coord_t                         f_x1, f_y1, f_x2, f_y2;
  logic signed [DELTA_BITS-1:0]   f_dx, f_dy;
  colour_t                        f_colour;

  logic                  accept;
  logic [DELTA_BITS-1:0] adx, ady;
  err_t                  two_adx, two_ady, err_x, err_y;
  logic                  x_major, fwd;

  assign req_stall = f_vld && cmd_full;
  assign accept    = req_valid && !req_stall;
  assign cmd_valid = f_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else if (!req_stall) begin
      f_vld <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_start  <= (req_data.req_type == REQ_START);
      f_x1     <= req_data.x_start;
      f_y1     <= req_data.y_start;
      f_x2     <= req_data.x_end;
      f_y2     <= req_data.y_end;
      f_dx     <= $signed({req_data.x_end[COORD_BITS-1], req_data.x_end})
                - $signed({req_data.x_start[COORD_BITS-1], req_data.x_start});
      f_dy     <= $signed({req_data.y_end[COORD_BITS-1], req_data.y_end})
                - $signed({req_data.y_start[COORD_BITS-1], req_data.y_start});
      f_colour <= '{red: req_data.red_in, green: req_data.green_in, blue: req_data.blue_in};
    end
  end

  // setup of the error term and start point
  always_comb begin
    adx     = f_dx[DELTA_BITS-1] ? DELTA_BITS'(-f_dx) : DELTA_BITS'(f_dx);
    ady     = f_dy[DELTA_BITS-1] ? DELTA_BITS'(-f_dy) : DELTA_BITS'(f_dy);
    two_adx = $signed({1'b0, adx, 1'b0});
    two_ady = $signed({1'b0, ady, 1'b0});
    err_x   = $signed({1'b0, ady, 1'b0}) - $signed({2'b00, adx});
    err_y   = $signed({1'b0, adx, 1'b0}) - $signed({2'b00, ady});
    x_major = (ady <= adx);
    fwd     = x_major ? !f_dx[DELTA_BITS-1] : !f_dy[DELTA_BITS-1];

    cmd.is_start  = f_start;
    cmd.x_major   = x_major;
    cmd.minor_up  = (f_dx[DELTA_BITS-1] && f_dy[DELTA_BITS-1])
                 || (!f_dx[DELTA_BITS-1] && f_dx != '0 && !f_dy[DELTA_BITS-1] && f_dy != '0);
    cmd.cur_x     = fwd ? f_x1 : f_x2;
    cmd.cur_y     = fwd ? f_y1 : f_y2;
    if (x_major) begin
      cmd.major_end    = fwd ? f_x2 : f_x1;
      cmd.err          = err_x;
      cmd.err_straight = two_ady;
      cmd.err_diag     = two_ady - two_adx;
    end else begin
      cmd.major_end    = fwd ? f_y2 : f_y1;
      cmd.err          = err_y;
      cmd.err_straight = two_adx;
      cmd.err_diag     = two_adx - two_ady;
    end
    cmd.colour = f_colour;
  end

endmodule
`default_nettype wire

// File: sv/blr_queue.sv
`default_nettype none
module blr_queue
  import blr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_data,
  output logic full,
  input  logic pop,
  output logic pop_valid,
  output cmd_t pop_data
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign full      = (count == QCNT_W'(QUEUE_DEPTH));
  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push_valid && !full;
  assign do_pop    = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

// File: sv/blr_back.sv
`default_nettype none
module blr_back
  import blr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  input  cmd_t                q_data,
  output logic                q_pop,
  input  logic [CFG_BITS-1:0] frame_width,
  input  logic [CFG_BITS-1:0] frame_height,
  output logic                res_valid,
  input  logic                res_stall,
  output res_t                res_data
);

  // line state
  coord_t  cur_x, cur_y, major_end;
  err_t    err, err_straight, err_diag;
  logic    x_major, minor_up, first_pending, line_active;
  colour_t colour;

  // step stage
  logic a_vld;
  pix_t a_pix;

  logic   out_ready, a_ready;
  coord_t nx, ny, major;
  err_t   nerr;
  logic   diag, last;

  logic [DIM_W-1:0]  w_c, h_c;
  logic [CMP_W-1:0]  x_ext, y_ext;
  logic              in_view;
  logic [PROD_W-1:0] idx_sum;
  res_t              res_next;

  assign out_ready = !res_valid || !res_stall;
  assign a_ready   = !a_vld || out_ready;
  assign q_pop     = q_valid && a_ready;

  // next pixel of the active line
  always_comb begin
    nx   = cur_x;
    ny   = cur_y;
    nerr = err;
    diag = x_major ? !err[ERR_BITS-1] : (!err[ERR_BITS-1] && err != '0);
    if (!first_pending) begin
      if (x_major) begin
        nx = cur_x + COORD_BITS'(1);
        if (diag) begin
          ny = minor_up ? cur_y + COORD_BITS'(1) : cur_y - COORD_BITS'(1);
        end
      end else begin
        ny = cur_y + COORD_BITS'(1);
        if (diag) begin
          nx = minor_up ? cur_x + COORD_BITS'(1) : cur_x - COORD_BITS'(1);
        end
      end
      nerr = diag ? err + err_diag : err + err_straight;
    end
    major = x_major ? nx : ny;
    last  = (major >= major_end);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld         <= 1'b0;
      line_active   <= 1'b0;
      first_pending <= 1'b0;
    end else begin
      if (a_ready) begin
        a_vld <= q_valid;
      end
      if (q_pop) begin
        if (q_data.is_start) begin
          line_active   <= 1'b1;
          first_pending <= 1'b1;
        end else if (line_active) begin
          first_pending <= 1'b0;
          line_active   <= !last;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (q_data.is_start) begin
        a_pix        <= '0;
        cur_x        <= q_data.cur_x;
        cur_y        <= q_data.cur_y;
        major_end    <= q_data.major_end;
        err          <= q_data.err;
        err_straight <= q_data.err_straight;
        err_diag     <= q_data.err_diag;
        x_major      <= q_data.x_major;
        minor_up     <= q_data.minor_up;
        colour       <= q_data.colour;
      end else if (line_active) begin
        cur_x <= nx;
        cur_y <= ny;
        err   <= nerr;
        a_pix <= '{pixel_valid: 1'b1, x: nx, y: ny, last: last, colour: colour};
      end else begin
        a_pix <= '0;
      end
    end
  end

  // frame test and framebuffer index
  always_comb begin
    w_c     = (DIM_W'(frame_width) > DIM_LIMIT) ? DIM_LIMIT : DIM_W'(frame_width);
    h_c     = (DIM_W'(frame_height) > DIM_LIMIT) ? DIM_LIMIT : DIM_W'(frame_height);
    x_ext   = CMP_W'($unsigned(a_pix.x));
    y_ext   = CMP_W'($unsigned(a_pix.y));
    in_view = a_pix.pixel_valid
           && !a_pix.x[COORD_BITS-1] && (x_ext < CMP_W'(w_c))
           && !a_pix.y[COORD_BITS-1] && (y_ext < CMP_W'(h_c));
    idx_sum = PROD_W'(y_ext[DIM_BITS-1:0]) * PROD_W'(w_c)
            + PROD_W'(x_ext[DIM_BITS-1:0]);

    res_next.pixel_valid = a_pix.pixel_valid;
    res_next.pixel_x     = a_pix.x;
    res_next.pixel_y     = a_pix.y;
    res_next.in_frame    = in_view;
    res_next.pixel_index = in_view ? INDEX_BITS'(idx_sum) : '0;
    res_next.red_out     = a_pix.colour.red;
    res_next.green_out   = a_pix.colour.green;
    res_next.blue_out    = a_pix.colour.blue;
    res_next.last_pixel  = a_pix.last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_ready) begin
      res_valid <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && a_vld) begin
      res_data <= res_next;
    end
  end

endmodule
`default_nettype wire

// File: sv/bresenham_line_rasterizer_core.sv
// Bresenham line rasterizer: one result transaction for every request transaction.
// Request channel (req_valid / req_stall / req_data): req_type start loads the
// endpoints and colour and returns an all-zero result; req_type step returns the
// next pixel of the line, or an all-zero result when no line is active.
// Pixels run from the endpoint with the lower major coordinate; last_pixel
// marks the end, after which steps return zero results until the next start.
// Pixels off the frame keep in_frame low and pixel_index zero.
// Config port: cfg_write with cfg_index selects frame_width (0) or frame_height
// (1); write only while no transaction is in flight.
// A request is registered in the front register, then passes the command queue,
// the step register and the output register before its result is presented.
// Throughput: one transaction per clock while nothing stalls; the step register
// updates the error term per step; the index multiply sits in the output stage.
// A four-entry command queue lets the front keep taking requests while the
// result side is stalled; req_stall rises only once the queue is full.
// While res_valid is high, res_stall holds the output register and all behind it.
// Reset (rst, synchronous) empties the pipeline, drops any active line and
// restores the frame size to 640 x 480.
`default_nettype none
module bresenham_line_rasterizer_core
  import blr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  req_t                req_data,
  output logic                res_valid,
  input  logic                res_stall,
  output res_t                res_data,
  input  logic                cfg_write,
  input  logic                cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  logic [CFG_BITS-1:0] frame_width;
  logic [CFG_BITS-1:0] frame_height;

  // front to queue
  logic cmd_valid, cmd_full;
  cmd_t cmd;

  // queue to back
  logic q_valid, q_pop;
  cmd_t q_data;

  // frame size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_WIDTH_RST;
      frame_height <= FRAME_HEIGHT_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_FRAME_WIDTH:  frame_width  <= cfg_data;
        CFG_FRAME_HEIGHT: frame_height <= cfg_data;
        default:          frame_width  <= frame_width;
      endcase
    end
  end

  // decode and line setup
  blr_front u_front (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .cmd_valid (cmd_valid),
    .cmd_full  (cmd_full),
    .cmd       (cmd)
  );

  // decouples setup from stepping
  blr_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_data  (cmd),
    .full       (cmd_full),
    .pop        (q_pop),
    .pop_valid  (q_valid),
    .pop_data   (q_data)
  );

  // line state, stepping, frame test and output register
  blr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (q_valid),
    .q_data       (q_data),
    .q_pop        (q_pop),
    .frame_width  (frame_width),
    .frame_height (frame_height),
    .res_valid    (res_valid),
    .res_stall    (res_stall),
    .res_data     (res_data)
  );

endmodule
`default_nettype wire
